/* rtl/core/bmm_pkg.sv */
// Shared types, constants and codes for the bipartite matching engine.
`default_nettype none

package bmm_pkg;

    // Fixed field widths of the request, result, command and status items.
    localparam int VERT_W   = 6;
    localparam int IDX_W    = 7;
    localparam int DIST_W   = 7;
    localparam int VERT_LIM = 64;

    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [DIST_W-1:0] DIST_INF = 7'h7f;

    // Request action codes.
    localparam logic [1:0] ACT_MARK  = 2'd0;
    localparam logic [1:0] ACT_EDGE  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [VERT_W-1:0] vertex_a;
        logic [VERT_W-1:0] vertex_b;
    } bmm_req_t;

    typedef struct packed {
        logic [VERT_W-1:0] match_count;
        logic [VERT_W-1:0] left_vertex;
        logic [VERT_W-1:0] right_vertex;
        logic              pair_valid;
        logic              last;
    } bmm_res_t;

    // Commands from the sequencer to the storage datapath.
    typedef struct packed {
        logic              edge_set;
        logic              edge_zero;
        logic [VERT_W-1:0] edge_wrow;
        logic [VERT_W-1:0] edge_wcol;
        logic [VERT_W-1:0] edge_rrow;
        logic              mark_set;
        logic [VERT_W-1:0] mark_vert;
        logic              marks_clr;
        logic              run_init;
        logic              part_we;
        logic [IDX_W-1:0]  part_waddr;
        logic [IDX_W-1:0]  part_wdata;
        logic [IDX_W-1:0]  part_raddr;
        logic              flag_set;
        logic              dist_we;
        logic [IDX_W-1:0]  dist_waddr;
        logic [DIST_W-1:0] dist_wdata;
        logic [IDX_W-1:0]  dist_raddr;
        logic              q_we;
        logic [VERT_W-1:0] q_waddr;
        logic [IDX_W-1:0]  q_wdata;
        logic [VERT_W-1:0] q_raddr;
        logic              s_we;
        logic [VERT_W-1:0] s_waddr;
        logic [IDX_W-1:0]  s_wvert;
        logic [IDX_W-1:0]  s_wnext;
        logic [VERT_W-1:0] s_raddr;
    } bmm_cmd_t;

    // Status from the storage datapath back to the sequencer.
    typedef struct packed {
        logic [VERT_LIM-1:0] edge_row;
        logic [VERT_LIM-1:0] left_marks;
        logic [VERT_LIM-1:0] matched;
        logic [IDX_W-1:0]    part_q;
        logic [DIST_W-1:0]   dist_q;
        logic [DIST_W-1:0]   dist0;
        logic [IDX_W-1:0]    q_q;
        logic [IDX_W-1:0]    s_vert_q;
        logic [IDX_W-1:0]    s_next_q;
    } bmm_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bmm_store.sv */
// Storage datapath: edge matrix, partner and layer memories, queue, stack and flags.
`default_nettype none

module bmm_store
    import bmm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bmm_cmd_t  cmd,
    output bmm_stat_t      stat
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int XW = $clog2(MAX_VERTICES + 1);
    localparam int XD = MAX_VERTICES + 1;

    logic [MAX_VERTICES-1:0] edge_mem [MAX_VERTICES];
    logic [IDX_W-1:0]        part_mem [XD];
    logic [DIST_W-1:0]       dist_mem [XD];
    logic [IDX_W-1:0]        q_mem    [MAX_VERTICES];
    logic [IDX_W-1:0]        sv_mem   [MAX_VERTICES];
    logic [IDX_W-1:0]        sn_mem   [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] edge_q_reg;
    logic [IDX_W-1:0]        part_q_reg;
    logic [DIST_W-1:0]       dist_q_reg;
    logic [IDX_W-1:0]        q_q_reg;
    logic [IDX_W-1:0]        sv_q_reg;
    logic [IDX_W-1:0]        sn_q_reg;

    logic [MAX_VERTICES-1:0] left_reg;
    logic [MAX_VERTICES-1:0] matched_reg;
    logic [XD-1:0]           part_vld_reg;
    logic [XD-1:0]           dist_vld_reg;
    logic [DIST_W-1:0]       dist0_reg;

    logic [IDX_W-1:0]        flag_idx;

    assign flag_idx = cmd.part_waddr - IDX_W'(1);

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.edge_zero)
        begin
            edge_mem[cmd.edge_wrow[AW-1:0]] <= '0;
        end
        else if (cmd.edge_set)
        begin
            edge_mem[cmd.edge_wrow[AW-1:0]][cmd.edge_wcol[AW-1:0]] <= 1'b1;
        end
        edge_q_reg <= edge_mem[cmd.edge_rrow[AW-1:0]];

        if (cmd.part_we)
        begin
            part_mem[cmd.part_waddr[XW-1:0]] <= cmd.part_wdata;
        end
        part_q_reg <= part_vld_reg[cmd.part_raddr[XW-1:0]] ?
                      part_mem[cmd.part_raddr[XW-1:0]] : '0;

        if (cmd.dist_we)
        begin
            dist_mem[cmd.dist_waddr[XW-1:0]] <= cmd.dist_wdata;
        end
        dist_q_reg <= dist_vld_reg[cmd.dist_raddr[XW-1:0]] ?
                      dist_mem[cmd.dist_raddr[XW-1:0]] : DIST_INF;

        if (cmd.q_we)
        begin
            q_mem[cmd.q_waddr[AW-1:0]] <= cmd.q_wdata;
        end
        q_q_reg <= q_mem[cmd.q_raddr[AW-1:0]];

        if (cmd.s_we)
        begin
            sv_mem[cmd.s_waddr[AW-1:0]] <= cmd.s_wvert;
            sn_mem[cmd.s_waddr[AW-1:0]] <= cmd.s_wnext;
        end
        sv_q_reg <= sv_mem[cmd.s_raddr[AW-1:0]];
        sn_q_reg <= sn_mem[cmd.s_raddr[AW-1:0]];
    end

    // Flags and valid bits. A clear valid bit reads a partner as zero, a layer as DIST_INF.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            matched_reg  <= '0;
            part_vld_reg <= '0;
            dist_vld_reg <= '0;
            dist0_reg    <= DIST_INF;
        end
        else
        begin
            if (cmd.marks_clr)
            begin
                left_reg <= '0;
            end
            else if (cmd.mark_set)
            begin
                left_reg[cmd.mark_vert[AW-1:0]] <= 1'b1;
            end

            if (cmd.run_init)
            begin
                matched_reg  <= '0;
                part_vld_reg <= '0;
                dist_vld_reg <= '0;
                dist0_reg    <= DIST_INF;
            end
            else
            begin
                if (cmd.part_we)
                begin
                    part_vld_reg[cmd.part_waddr[XW-1:0]] <= 1'b1;
                end
                if (cmd.flag_set)
                begin
                    matched_reg[flag_idx[AW-1:0]] <= 1'b1;
                end
                if (cmd.dist_we)
                begin
                    dist_vld_reg[cmd.dist_waddr[XW-1:0]] <= 1'b1;
                    if (cmd.dist_waddr == '0)
                    begin
                        dist0_reg <= cmd.dist_wdata;
                    end
                end
            end
        end
    end

    assign stat = '{edge_row:   VERT_LIM'(edge_q_reg),
                    left_marks: VERT_LIM'(left_reg),
                    matched:    VERT_LIM'(matched_reg),
                    part_q:     part_q_reg,
                    dist_q:     dist_q_reg,
                    dist0:      dist0_reg,
                    q_q:        q_q_reg,
                    s_vert_q:   sv_q_reg,
                    s_next_q:   sn_q_reg};

endmodule

`default_nettype wire

/* rtl/core/bmm_ctrl.sv */
// Sequencer: request decode, layering search, stack-driven augmentation and result emission.
`default_nettype none

module bmm_ctrl
    import bmm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire bmm_req_t  request,
    output logic           busy,
    output logic           result_valid,
    output bmm_res_t       result,
    output bmm_cmd_t       cmd,
    input  wire bmm_stat_t stat
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_BI   = 5'd2;
    localparam logic [4:0] S_BQ   = 5'd3;
    localparam logic [4:0] S_BU   = 5'd4;
    localparam logic [4:0] S_BD   = 5'd5;
    localparam logic [4:0] S_BS   = 5'd6;
    localparam logic [4:0] S_BP   = 5'd7;
    localparam logic [4:0] S_BW   = 5'd8;
    localparam logic [4:0] S_AI   = 5'd9;
    localparam logic [4:0] S_FL   = 5'd10;
    localparam logic [4:0] S_FD   = 5'd11;
    localparam logic [4:0] S_DS   = 5'd12;
    localparam logic [4:0] S_DPT  = 5'd13;
    localparam logic [4:0] S_DW   = 5'd14;
    localparam logic [4:0] S_DP   = 5'd15;
    localparam logic [4:0] S_CM   = 5'd16;
    localparam logic [4:0] S_C1   = 5'd17;
    localparam logic [4:0] S_C2   = 5'd18;
    localparam logic [4:0] S_EM   = 5'd19;
    localparam logic [4:0] S_EO   = 5'd20;

    localparam logic [IDX_W-1:0] NV      = IDX_W'(MAX_VERTICES);
    localparam logic [IDX_W-1:0] NV_LAST = IDX_W'(MAX_VERTICES - 1);
    localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);

    logic [4:0]        st_reg, st_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  v_reg, v_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  depth_reg, depth_next;
    logic [IDX_W-1:0]  cu_reg, cu_next;
    logic [DIST_W-1:0] du_reg, du_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [VERT_W-1:0] cnt_reg, cnt_next;
    logic              res_vld_reg, res_vld_next;
    bmm_res_t          res_reg, res_next;

    logic              accept;
    logic              cand;
    logic [VERT_LIM-1:0] emask;
    logic [VERT_LIM-1:0] emask_hi;
    logic [IDX_W-1:0]  uq_m1;
    logic [IDX_W-1:0]  cu_m1;
    logic [IDX_W-1:0]  right_m1;
    logic [IDX_W:0]    want;

    function automatic logic [VERT_W-1:0] depth_m1(input logic [IDX_W-1:0] d);
        logic [IDX_W-1:0] t;
        t = d - IDX_W'(1);
        return t[VERT_W-1:0];
    endfunction

    assign accept   = start && (st_reg == S_IDLE);
    assign cand     = stat.edge_row[v_reg[VERT_W-1:0]] && !stat.left_marks[v_reg[VERT_W-1:0]];
    assign emask    = stat.left_marks & stat.matched;
    assign emask_hi = (emask >> i_reg) >> 1;
    assign uq_m1    = stat.q_q - ONE;
    assign cu_m1    = cu_reg - ONE;
    assign right_m1 = stat.part_q - ONE;
    assign want     = {1'b0, du_reg} + (IDX_W + 1)'(1);

    always_comb
    begin
        st_next      = st_reg;
        i_next       = i_reg;
        v_next       = v_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        depth_next   = depth_reg;
        cu_next      = cu_reg;
        du_next      = du_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        res_vld_next = 1'b0;
        res_next     = res_reg;

        cmd            = '0;
        cmd.edge_rrow  = (st_reg == S_BU) ? uq_m1[VERT_W-1:0] : cu_m1[VERT_W-1:0];
        cmd.part_raddr = (st_reg == S_EM) ? i_reg + ONE : v_reg + ONE;
        cmd.dist_raddr = ((st_reg == S_BU) ? stat.q_q :
                          ((st_reg == S_BP) || (st_reg == S_DPT)) ? stat.part_q : cu_reg);
        cmd.q_raddr    = head_reg[VERT_W-1:0];
        cmd.q_waddr    = tail_reg[VERT_W-1:0];
        cmd.s_raddr    = k_reg[VERT_W-1:0];

        case (st_reg)
            S_CLR:
            begin
                cmd.edge_zero = 1'b1;
                cmd.edge_wrow = i_reg[VERT_W-1:0];
                cmd.marks_clr = 1'b1;
                i_next        = i_reg + ONE;
                if (i_reg == NV_LAST)
                begin
                    i_next  = '0;
                    st_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.action)
                        ACT_MARK:
                        begin
                            cmd.mark_set  = ({1'b0, request.vertex_a} < NV);
                            cmd.mark_vert = request.vertex_a;
                        end
                        ACT_EDGE:
                        begin
                            cmd.edge_set  = ({1'b0, request.vertex_a} < NV) &&
                                            ({1'b0, request.vertex_b} < NV);
                            cmd.edge_wrow = request.vertex_a;
                            cmd.edge_wcol = request.vertex_b;
                        end
                        ACT_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            cnt_next     = '0;
                            i_next       = '0;
                            head_next    = '0;
                            tail_next    = '0;
                            st_next      = S_BI;
                        end
                        default:
                        begin
                            i_next  = '0;
                            st_next = S_CLR;
                        end
                    endcase
                end
            end

            // Layer zero holds every free left vertex.
            S_BI:
            begin
                if (i_reg == NV)
                begin
                    cmd.dist_we    = 1'b1;
                    cmd.dist_waddr = '0;
                    cmd.dist_wdata = DIST_INF;
                    st_next        = S_BQ;
                end
                else
                begin
                    if (stat.left_marks[i_reg[VERT_W-1:0]])
                    begin
                        cmd.dist_we    = 1'b1;
                        cmd.dist_waddr = i_reg + ONE;
                        if (stat.matched[i_reg[VERT_W-1:0]])
                        begin
                            cmd.dist_wdata = DIST_INF;
                        end
                        else
                        begin
                            cmd.dist_wdata = '0;
                            cmd.q_we       = 1'b1;
                            cmd.q_wdata    = i_reg + ONE;
                            tail_next      = tail_reg + ONE;
                        end
                    end
                    i_next = i_reg + ONE;
                end
            end

            S_BQ:
            begin
                if (head_reg == tail_reg)
                begin
                    i_next = '0;
                    if (stat.dist0 != DIST_INF)
                    begin
                        st_next = S_AI;
                    end
                    else
                    begin
                        st_next = S_EM;
                    end
                end
                else
                begin
                    head_next = head_reg + ONE;
                    st_next   = S_BU;
                end
            end

            S_BU:
            begin
                cu_next = stat.q_q;
                st_next = S_BD;
            end

            S_BD:
            begin
                if (stat.dist_q >= stat.dist0)
                begin
                    st_next = S_BQ;
                end
                else
                begin
                    du_next = stat.dist_q;
                    v_next  = '0;
                    st_next = S_BS;
                end
            end

            S_BS:
            begin
                if (v_reg == NV)
                begin
                    st_next = S_BQ;
                end
                else if (cand)
                begin
                    st_next = S_BP;
                end
                else
                begin
                    v_next = v_reg + ONE;
                end
            end

            S_BP:
            begin
                st_next = S_BW;
            end

            S_BW:
            begin
                if (stat.dist_q == DIST_INF)
                begin
                    cmd.dist_we    = 1'b1;
                    cmd.dist_waddr = stat.part_q;
                    cmd.dist_wdata = du_reg + DIST_W'(1);
                    if (stat.part_q != '0)
                    begin
                        cmd.q_we    = 1'b1;
                        cmd.q_wdata = stat.part_q;
                        tail_next   = tail_reg + ONE;
                    end
                end
                v_next  = v_reg + ONE;
                st_next = S_BS;
            end

            S_AI:
            begin
                if (i_reg == NV)
                begin
                    i_next    = '0;
                    head_next = '0;
                    tail_next = '0;
                    st_next   = S_BI;
                end
                else if (stat.left_marks[i_reg[VERT_W-1:0]] &&
                         !stat.matched[i_reg[VERT_W-1:0]])
                begin
                    cu_next    = i_reg + ONE;
                    depth_next = ONE;
                    v_next     = '0;
                    st_next    = S_FL;
                end
                else
                begin
                    i_next = i_reg + ONE;
                end
            end

            S_FL:
            begin
                st_next = S_FD;
            end

            S_FD:
            begin
                du_next = stat.dist_q;
                st_next = S_DS;
            end

            S_DS:
            begin
                if (v_reg == NV)
                begin
                    // Dead end: drop the vertex from the layering and pop its frame.
                    cmd.dist_we    = 1'b1;
                    cmd.dist_waddr = cu_reg;
                    cmd.dist_wdata = DIST_INF;
                    cmd.s_raddr    = depth_reg[VERT_W-1:0] - VERT_W'(2);
                    depth_next     = depth_reg - ONE;
                    if (depth_reg == ONE)
                    begin
                        i_next  = i_reg + ONE;
                        st_next = S_AI;
                    end
                    else
                    begin
                        st_next = S_DP;
                    end
                end
                else if (cand)
                begin
                    st_next = S_DPT;
                end
                else
                begin
                    v_next = v_reg + ONE;
                end
            end

            S_DPT:
            begin
                st_next = S_DW;
            end

            S_DW:
            begin
                if ({1'b0, stat.dist_q} == want)
                begin
                    cmd.s_we    = 1'b1;
                    cmd.s_waddr = depth_m1(depth_reg);
                    cmd.s_wvert = cu_reg;
                    cmd.s_wnext = v_reg + ONE;
                    if (stat.part_q == '0)
                    begin
                        k_next  = '0;
                        st_next = S_CM;
                    end
                    else
                    begin
                        cu_next    = stat.part_q;
                        v_next     = '0;
                        depth_next = depth_reg + ONE;
                        st_next    = S_FL;
                    end
                end
                else
                begin
                    v_next  = v_reg + ONE;
                    st_next = S_DS;
                end
            end

            S_DP:
            begin
                cu_next = stat.s_vert_q;
                v_next  = stat.s_next_q;
                st_next = S_FL;
            end

            // Flip the augmenting path one frame at a time.
            S_CM:
            begin
                if (k_reg == depth_reg)
                begin
                    cnt_next = cnt_reg + VERT_W'(1);
                    i_next   = i_reg + ONE;
                    st_next  = S_AI;
                end
                else
                begin
                    st_next = S_C1;
                end
            end

            S_C1:
            begin
                cmd.part_we    = 1'b1;
                cmd.part_waddr = stat.s_vert_q;
                cmd.part_wdata = stat.s_next_q;
                cmd.flag_set   = 1'b1;
                st_next        = S_C2;
            end

            S_C2:
            begin
                cmd.part_we    = 1'b1;
                cmd.part_waddr = stat.s_next_q;
                cmd.part_wdata = stat.s_vert_q;
                k_next         = k_reg + ONE;
                st_next        = S_CM;
            end

            S_EM:
            begin
                if (i_reg == NV)
                begin
                    if (cnt_reg == '0)
                    begin
                        res_vld_next = 1'b1;
                        res_next     = '{match_count: '0, left_vertex: '0,
                                        right_vertex: '0, pair_valid: 1'b0, last: 1'b1};
                    end
                    i_next  = '0;
                    st_next = S_IDLE;
                end
                else if (emask[i_reg[VERT_W-1:0]])
                begin
                    st_next = S_EO;
                end
                else
                begin
                    i_next = i_reg + ONE;
                end
            end

            S_EO:
            begin
                res_vld_next = 1'b1;
                res_next     = '{match_count: cnt_reg, left_vertex: i_reg[VERT_W-1:0],
                                right_vertex: right_m1[VERT_W-1:0], pair_valid: 1'b1,
                                last: (emask_hi == '0)};
                i_next       = i_reg + ONE;
                st_next      = S_EM;
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_CLR;
            i_reg       <= '0;
            v_reg       <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            depth_reg   <= '0;
            cu_reg      <= '0;
            du_reg      <= '0;
            k_reg       <= '0;
            cnt_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            i_reg       <= i_next;
            v_reg       <= v_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            depth_reg   <= depth_next;
            cu_reg      <= cu_next;
            du_reg      <= du_next;
            k_reg       <= k_next;
            cnt_reg     <= cnt_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy         = (st_reg != S_IDLE);
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

/* rtl/core/bipartite_max_matching.sv */
// Top level of the Hopcroft-Karp maximum bipartite matching engine.
`default_nettype none

// A request is taken at a rising edge where start is high and busy is low. Marking a left
// vertex and adding an edge never raise busy, so graph loading runs at one request per
// cycle. A clear request, and the block itself after reset, zero the edge matrix one row
// per cycle, with busy high. A run request holds busy high while the search walks the
// stored graph: every layering round sets up the layers and then, per queued vertex,
// scans its columns and probes each real edge; the augmentation rounds scan columns the
// same way, enter frames, pop back out of dead ends and flip the pairs of each path. The
// pace is set by the single read port of the partner and layer memories, which every edge
// probe goes through in turn. Results then come out one matched pair per emit step in
// ascending left vertex order, each shown for exactly one cycle on result with
// result_valid high; the receiver cannot stall them, so it must take every strobe. A run
// with no pairs gives one result with pair_valid low and last high.

module bipartite_max_matching
    import bmm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire bmm_req_t request,
    output logic          busy,
    output logic          result_valid,
    output bmm_res_t      result
);

    // Sequencer and storage talk only through the command and status groups.
    bmm_cmd_t  cmd;
    bmm_stat_t stat;

    bmm_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

    bmm_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire

/* rtl/core/bmm_checker.sv */
// Port-level checks for the matching engine, bound to the top level.
`default_nettype none

module bmm_checker
    import bmm_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire bmm_req_t request,
    input wire logic     busy,
    input wire logic     result_valid,
    input wire bmm_res_t result
);

    // Results only come out of a run, which holds busy in the cycle before.
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a preceding run");

    // Only the final result of a run may lack a pair.
    a_mid_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> result.pair_valid)
        else $error("non-final result without a pair");

    // An empty result reports an empty matching.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.pair_valid) |-> (result.match_count == '0))
        else $error("empty result with nonzero count");

    // More results follow a non-final one, so the run is still in progress.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> busy)
        else $error("run ended before its last result");

    // A run request always occupies the block.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.action == ACT_RUN)) |=> busy)
        else $error("run request did not raise busy");

endmodule

bind bipartite_max_matching bmm_checker u_bmm_checker (.*);

`default_nettype wire

/* bench/bipartite_max_matching_chk.sv */
// Checker for the matching engine: predicts each run's pairs and compares the results.
`timescale 1ns / 1ps

module bipartite_max_matching_chk
    import bmm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire bmm_req_t request,
    input  wire logic     result_valid,
    input  wire bmm_res_t result,
    output int            fail_count,
    output int            pairs_pending,
    output int            pairs_checked
);

    localparam int NV  = 64;
    localparam int INF = 127;

    logic [NV-1:0] adj [NV];
    logic [NV-1:0] left_set;
    logic [NV-1:0] matched;
    int            mate [NV+1];
    int            layer [NV+1];
    int            bfs_q [NV];
    int            dfs_vert [NV+1];
    int            dfs_next [NV+1];
    bmm_res_t      pair_q [$];

    function automatic bit right_nbr(int u, int v);
        return v >= 0 && v < NV && u >= 1 && u <= NV && adj[u-1][v] && !left_set[v];
    endfunction

    function automatic bit build_layers();
        int head;
        int tail;
        int u;
        int w;
        head = 0;
        tail = 0;
        for (int i = 0; i < NV; i++) begin
            if (!left_set[i]) continue;
            if (mate[i+1] == 0) begin
                layer[i+1] = 0;
                if (tail < NV) begin
                    bfs_q[tail] = i + 1;
                    tail++;
                end
            end else begin
                layer[i+1] = INF;
            end
        end
        layer[0] = INF;
        while (head < tail) begin
            u = bfs_q[head % NV];
            head++;
            if (layer[u] >= layer[0]) continue;
            for (int v = 0; v < NV; v++) begin
                if (!right_nbr(u, v)) continue;
                w = mate[v+1] & 127;
                if (w > NV) continue;
                if (layer[w] == INF) begin
                    layer[w] = (layer[u] + 1) & 127;
                    if (w != 0 && tail < NV) begin
                        bfs_q[tail] = w;
                        tail++;
                    end
                end
            end
        end
        return layer[0] != INF;
    endfunction

    function automatic bit augment_path(int root);
        int depth;
        int fi;
        int u;
        int want;
        int found;
        int w;
        int p;
        int lu;
        int rv;
        depth = 1;
        dfs_vert[0] = root;
        dfs_next[0] = 0;
        while (depth > 0) begin
            fi = (depth - 1) % (NV + 1);
            u = dfs_vert[fi];
            want = layer[u] + 1;
            found = NV;
            w = 0;
            for (int v = dfs_next[fi]; v < NV; v++) begin
                if (!right_nbr(u, v)) continue;
                p = mate[v+1] & 127;
                if (p > NV) continue;
                if (layer[p] == want) begin
                    found = v;
                    w = p;
                    break;
                end
            end
            if (found == NV) begin
                layer[u] = INF;
                depth--;
                continue;
            end
            dfs_next[fi] = found + 1;
            if (w == 0) begin
                // Flip every edge along the stacked path.
                for (int k = 0; k < depth && k < NV + 1; k++) begin
                    lu = dfs_vert[k];
                    rv = dfs_next[k] - 1;
                    if (lu < 1 || lu > NV || rv < 0 || rv >= NV) continue;
                    mate[lu] = rv + 1;
                    mate[rv+1] = lu;
                    matched[lu-1] = 1'b1;
                end
                return 1'b1;
            end
            if (depth >= NV + 1) begin
                layer[w] = INF;
                continue;
            end
            dfs_vert[depth] = w;
            dfs_next[depth] = 0;
            depth++;
        end
        return 1'b0;
    endfunction

    task automatic predict_run();
        int       count;
        int       n;
        bmm_res_t r;
        bmm_res_t run_pairs [$];
        for (int i = 0; i <= NV; i++) begin
            mate[i] = 0;
            layer[i] = INF;
        end
        matched = '0;
        count = 0;
        while (build_layers()) begin
            for (int i = 0; i < NV; i++)
                if (left_set[i] && mate[i+1] == 0 && augment_path(i + 1))
                    count++;
        end
        n = 0;
        for (int i = 0; i < NV && n < 32; i++) begin
            if (!left_set[i] || !matched[i]) continue;
            r.match_count  = count[VERT_W-1:0];
            r.left_vertex  = i[VERT_W-1:0];
            r.right_vertex = 6'(mate[i+1] - 1);
            r.pair_valid   = 1'b1;
            r.last         = 1'b0;
            run_pairs.push_back(r);
            n++;
        end
        if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            run_pairs.push_back(r);
        end else begin
            run_pairs[n-1].last = 1'b1;
        end
        foreach (run_pairs[k]) pair_q.push_back(run_pairs[k]);
    endtask

    task automatic clear_graph();
        for (int i = 0; i < NV; i++) adj[i] = '0;
        left_set = '0;
        matched = '0;
        for (int i = 0; i <= NV; i++) begin
            mate[i] = 0;
            layer[i] = INF;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bmm_res_t exp_r;
        if (!rst_n) begin
            clear_graph();
            pair_q.delete();
            fail_count = 0;
            pairs_checked = 0;
            pairs_pending = 0;
        end else begin
            if (result_valid) begin
                if (pair_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count++;
                end else begin
                    exp_r = pair_q.pop_front();
                    pairs_checked++;
                    if (result.match_count !== exp_r.match_count
                        || result.left_vertex !== exp_r.left_vertex
                        || result.right_vertex !== exp_r.right_vertex
                        || result.pair_valid !== exp_r.pair_valid
                        || result.last !== exp_r.last) begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, exp_r, result);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                case (request.action)
                    ACT_MARK:  left_set[request.vertex_a] = 1'b1;
                    ACT_EDGE:  adj[request.vertex_a][request.vertex_b] = 1'b1;
                    ACT_CLEAR: clear_graph();
                    default:   predict_run();
                endcase
            end
            pairs_pending = pair_q.size();
        end
    end

endmodule

/* bench/bipartite_max_matching_tb.sv */
// Testbench top: drives graph loading and run requests into the matching engine.
`timescale 1ns / 1ps

module bipartite_max_matching_tb;
    import bmm_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     result_valid;
    bmm_req_t request;
    bmm_res_t result;
    int       fail_count;
    int       pairs_pending;
    int       pairs_checked;
    int       sent_count;
    int       run_count;
    int       cycle_count;
    bit       idle_on;

    localparam int CYCLE_LIMIT = 3000000;

    bipartite_max_matching u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    bipartite_max_matching_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_valid  (result_valid),
        .result        (result),
        .fail_count    (fail_count),
        .pairs_pending (pairs_pending),
        .pairs_checked (pairs_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung search or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bipartite_max_matching verification failed");
            $finish;
        end
    end

    // Present one request at a falling edge and hold it until busy is low, so the
    // request is taken at the following rising edge. Start is left high afterwards;
    // the next call either reuses it or drops it for an idle gap.
    task automatic send(input logic [1:0] act, input int a, input int b);
        while (idle_on && $urandom_range(99) < 32)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        request.action   = act;
        request.vertex_a = a[VERT_W-1:0];
        request.vertex_b = b[VERT_W-1:0];
        while (busy) @(negedge clk);
        @(posedge clk);
        sent_count++;
        if (act == ACT_RUN) run_count++;
    endtask

    // Build a small random graph around a few left vertices and run it. Most edges
    // go from a marked vertex; a few are noise that the search must skip.
    task automatic random_graph();
        int lefts [$];
        int nl;
        int ne;
        int v;
        if ($urandom_range(3) != 0) send(ACT_CLEAR, $urandom, $urandom);
        nl = $urandom_range(1, 8);
        for (int i = 0; i < nl; i++)
        begin
            v = $urandom_range(63);
            lefts.push_back(v);
            send(ACT_MARK, v, $urandom);
        end
        ne = $urandom_range(1, 14);
        for (int i = 0; i < ne; i++)
        begin
            if ($urandom_range(9) == 0)
                send(ACT_EDGE, $urandom_range(63), $urandom_range(63));
            else
                send(ACT_EDGE, lefts[$urandom_range(nl - 1)], $urandom_range(63));
        end
        send(ACT_RUN, $urandom, $urandom);
    endtask

    initial
    begin
        cycle_count = 0;
        sent_count = 0;
        run_count = 0;
        idle_on = 1'b1;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A run on an empty graph gives the empty matching.
        send(ACT_RUN, 0, 0);
        // A maximum matching of two pairs that needs an augmenting path through a taken vertex.
        send(ACT_MARK, 0, 0);
        send(ACT_MARK, 63, 63);
        send(ACT_MARK, 64 + 5, 0);
        send(ACT_EDGE, 0, 10);
        send(ACT_EDGE, 0, 20);
        send(ACT_EDGE, 63, 10);
        send(ACT_EDGE, 63, 10);    // duplicate edge changes nothing
        send(ACT_EDGE, 5, 63);
        send(ACT_EDGE, 5, 0);      // right end is a left vertex, never used
        send(ACT_EDGE, 30, 40);    // left end is not marked, never used
        send(ACT_RUN, 63, 63);
        // A second run starts from scratch and must give the same answer.
        send(ACT_RUN, 0, 0);
        // Marking the right end later changes what the stored edge means.
        send(ACT_MARK, 10, 0);
        send(ACT_RUN, 0, 0);
        send(ACT_CLEAR, 63, 63);
        send(ACT_RUN, 0, 0);

        // Hold off until the last run has fully drained.
        @(negedge clk);
        start = 1'b0;
        wait (pairs_pending == 0);

        // Random graphs; a middle stretch runs with no idle gaps at all.
        while (sent_count < 110)
        begin
            idle_on = !(sent_count > 50 && sent_count < 90);
            if ($urandom_range(9) == 0)
                send(2'($urandom_range(3)), $urandom, $urandom);
            else
                random_graph();
        end

        @(negedge clk);
        start = 1'b0;
        wait (pairs_pending == 0);
        repeat (200) @(posedge clk);

        $display("Sent %0d requests including %0d runs; %0d results checked.",
                 sent_count, run_count, pairs_checked);
        if (fail_count == 0)
            $display("bipartite_max_matching verification clean");
        else
            $display("bipartite_max_matching verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bmm_pkg.sv
rtl/core/bmm_store.sv
rtl/core/bmm_ctrl.sv
rtl/core/bipartite_max_matching.sv
rtl/core/bmm_checker.sv
bench/bipartite_max_matching_chk.sv
bench/bipartite_max_matching_tb.sv
